>>> src/stepper_trapezoid_ramp_generator_top_macros.svh
// Assertion macros for the step ramp generator.
// Each check is clocked on clk and disabled while rst_n is low.
`ifndef STEPPER_TRAPEZOID_RAMP_GENERATOR_TOP_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_GENERATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define STRG_ASSERT_IMP(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("strg assertion failed");
// Next-cycle implication.
`define STRG_ASSERT_NXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("strg assertion failed");
`else
`define STRG_ASSERT_IMP(lbl, pre, con)
`define STRG_ASSERT_NXT(lbl, pre, con)
`endif
`endif

>>> src/strg_pkg.sv
`default_nettype none
package strg_pkg;

  localparam int POS_W       = 32;
  localparam int PERIOD_W    = 32;
  localparam int FRAC_W      = 16;
  localparam int DECEL_W     = 31;
  localparam int ACCEL_W     = 32;
  localparam int TICK_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Iterative a*p*p*p: one 32x32 limb product per cycle
  localparam int LIMB_W      = 32;
  localparam int LIMBS       = 4;
  localparam int LIMB_IDX_W  = 2;
  localparam int MUL_PASSES  = 3;
  localparam int MUL_STEPS   = LIMBS * MUL_PASSES;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int PROD_W      = LIMBS * LIMB_W;
  localparam int ACCEL_SHIFT = 48 + 2 * FRAC_W;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST   = 32'd87381333;
  localparam logic [PERIOD_W-1:0] FIRST_PERIOD_RST = 32'd2930859049;
  localparam logic [DECEL_W-1:0]  DECEL_STEPS_RST  = 31'd1125;
  localparam logic [ACCEL_W-1:0]  ACCEL_COEFF_RST  = 32'd70369;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_SETPOS = 2'd2,
    FUNC_LATCH  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PERIOD   = 2'd0,
    REG_FIRST_PERIOD = 2'd1,
    REG_DECEL_STEPS  = 2'd2,
    REG_ACCEL_COEFF  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic limb_last;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic step;
  } dp_status_t;

endpackage
`default_nettype wire

>>> src/stepper_trapezoid_ramp_generator_top.sv
// The result of an item is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while the result register can be refilled, except an item
// that issues a step: after its accept the input stalls while the next period a*p^3 is
// built from 12 limb products on one 32x32 multiplier and then committed.
// Reset: synchronous, active low; motion state clears to zero, configuration registers take their defaults.
`default_nettype none
`include "stepper_trapezoid_ramp_generator_top_macros.svh"
module stepper_trapezoid_ramp_generator_top import strg_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_func,
  input  wire logic signed [POS_W-1:0] in_value,
  input  wire logic                    in_switch_active,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_step_pulse,
  output logic                         out_direction,
  output logic signed [POS_W-1:0]      out_position,
  output logic                         out_done_res,
  output logic                         out_stop_fault
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  strg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  strg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_func          (in_func),
    .in_value         (in_value),
    .in_switch_active (in_switch_active),
    .cmd              (cmd),
    .status           (status),
    .out_step_pulse   (out_step_pulse),
    .out_direction    (out_direction),
    .out_position     (out_position),
    .out_done_res     (out_done_res),
    .out_stop_fault   (out_stop_fault)
  );

  // Checks
  `STRG_ASSERT_IMP(a_busy_stalls, cmd.mul_en || cmd.commit, in_stall)
  `STRG_ASSERT_NXT(a_step_starts_mul, cmd.load && status.step, cmd.mul_en)
  `STRG_ASSERT_NXT(a_result_held, out_valid && out_stall, out_valid)
  `STRG_ASSERT_IMP(a_no_load_in_mul, cmd.mul_en, !cmd.load)

endmodule
`default_nettype wire

>>> src/strg_ctrl.sv
`default_nettype none
module strg_ctrl import strg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MUL    = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [MUL_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   accept;

  // Take an item only when idle and the output register can be refilled
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Sequence the period update after a step
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.load      = accept;
    cmd.limb_last = (cnt_r[LIMB_IDX_W-1:0] == LIMB_IDX_W'(LIMBS - 1));
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && status.step) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + MUL_CNT_W'(1);
        if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold a result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/strg_dp.sv
`default_nettype none
module strg_dp import strg_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [1:0]              in_func,
  input  wire logic signed [POS_W-1:0] in_value,
  input  wire logic                    in_switch_active,
  input  wire ctrl_cmd_t               cmd,
  output dp_status_t                   status,
  output logic                         out_step_pulse,
  output logic                         out_direction,
  output logic signed [POS_W-1:0]      out_position,
  output logic                         out_done_res,
  output logic                         out_stop_fault
);

  // Configuration
  logic [PERIOD_W-1:0] min_period_r, first_period_r;
  logic [DECEL_W-1:0]  decel_steps_r;
  logic [ACCEL_W-1:0]  accel_r;

  // Motion state
  logic [POS_W-1:0]    cur_r, cur_nxt;
  logic [POS_W-1:0]    target_r, target_nxt;
  logic                reverse_r, reverse_nxt;
  logic [DECEL_W-1:0]  decel_point_r, decel_point_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                decel_r, decel_nxt;
  logic [TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic                latch_r, latch_nxt;

  // Period multiplier
  logic [PROD_W-1:0]     w_r;
  logic [LIMB_W-1:0]     carry_r;
  logic [2*LIMB_W-1:0]   prod;

  // Output register
  logic                step_r, dir_r, done_r, fault_r;
  logic [POS_W-1:0]    pos_r;

  logic                step, fault;
  logic [POS_W:0]      diff_start, diff_tick;
  logic [POS_W:0]      dist_start, dist_tick;
  logic [TICK_W-1:0]   elapsed_inc;

  logic [PROD_W-ACCEL_SHIFT-LIMB_W-1:0] delta_hi;
  logic [PERIOD_W-1:0] delta;
  logic                delta_sat;
  logic [PERIOD_W:0]   period_sum;
  logic [PERIOD_W-1:0] period_ramp;

  // Distances of the sign-extended positions
  assign diff_start = {in_value[POS_W-1], in_value} - {cur_r[POS_W-1], cur_r};
  assign diff_tick  = {target_r[POS_W-1], target_r} - {cur_r[POS_W-1], cur_r};
  assign dist_start = diff_start[POS_W] ? (~diff_start + (POS_W+1)'(1)) : diff_start;
  assign dist_tick  = diff_tick[POS_W] ? (~diff_tick + (POS_W+1)'(1)) : diff_tick;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + TICK_W'(1);

  // Apply one item to the motion state
  always_comb begin
    cur_nxt         = cur_r;
    target_nxt      = target_r;
    reverse_nxt     = reverse_r;
    decel_point_nxt = decel_point_r;
    period_nxt      = period_r;
    decel_nxt       = decel_r;
    elapsed_nxt     = elapsed_r;
    latch_nxt       = latch_r;
    step            = 1'b0;
    fault           = 1'b0;
    case (func_t'(in_func))
      FUNC_START: begin
        target_nxt  = in_value;
        reverse_nxt = diff_start[POS_W];
        if (dist_start <= {1'b0, decel_steps_r, 1'b0}) begin
          decel_point_nxt = dist_start[DECEL_W:1];
        end else begin
          decel_point_nxt = decel_steps_r;
        end
        period_nxt  = first_period_r;
        decel_nxt   = 1'b0;
        elapsed_nxt = '0;
      end
      FUNC_SETPOS: begin
        cur_nxt    = in_value;
        target_nxt = in_value;
      end
      FUNC_LATCH: begin
        latch_nxt = in_value[0];
      end
      FUNC_TICK: begin
        if (cur_r != target_r) begin
          if (in_switch_active && !latch_r) begin
            latch_nxt  = 1'b1;
            target_nxt = cur_r;
            fault      = 1'b1;
          end else if (elapsed_inc >=
                       {{(TICK_W-(PERIOD_W-FRAC_W)){1'b0}}, period_r[PERIOD_W-1:FRAC_W]}) begin
            // Issue a step; the new period follows from the multiplier
            if (dist_tick == {2'b00, decel_point_r}) begin
              decel_nxt = !decel_r;
            end
            cur_nxt     = reverse_r ? cur_r - POS_W'(1) : cur_r + POS_W'(1);
            elapsed_nxt = '0;
            step        = 1'b1;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign status.step = step;

  // One limb product per cycle, rotating the word through the low limb
  assign prod = w_r[LIMB_W-1:0] * period_r + {{LIMB_W{1'b0}}, carry_r};

  // Ramp the period by floor(a*p^3 / 2^shift) and clamp
  assign delta_hi   = w_r[PROD_W-1:ACCEL_SHIFT+LIMB_W];
  assign delta      = w_r[ACCEL_SHIFT+LIMB_W-1:ACCEL_SHIFT];
  assign delta_sat  = |delta_hi;
  assign period_sum = {1'b0, period_r} + {1'b0, delta};

  always_comb begin
    if (decel_r) begin
      period_ramp = (delta_sat || period_sum[PERIOD_W]) ? '1 : period_sum[PERIOD_W-1:0];
    end else begin
      period_ramp = (delta_sat || delta >= period_r) ? '0 : period_r - delta;
    end
    if (period_ramp < min_period_r) begin
      period_ramp = min_period_r;
    end
  end

  // Configuration and motion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r   <= MIN_PERIOD_RST;
      first_period_r <= FIRST_PERIOD_RST;
      decel_steps_r  <= DECEL_STEPS_RST;
      accel_r        <= ACCEL_COEFF_RST;
      cur_r          <= '0;
      target_r       <= '0;
      reverse_r      <= 1'b0;
      decel_point_r  <= '0;
      period_r       <= '0;
      decel_r        <= 1'b0;
      elapsed_r      <= '0;
      latch_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_PERIOD:   min_period_r   <= cfg_data[PERIOD_W-1:0];
          REG_FIRST_PERIOD: first_period_r <= cfg_data[PERIOD_W-1:0];
          REG_DECEL_STEPS:  decel_steps_r  <= cfg_data[DECEL_W-1:0];
          REG_ACCEL_COEFF:  accel_r        <= cfg_data[ACCEL_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        cur_r         <= cur_nxt;
        target_r      <= target_nxt;
        reverse_r     <= reverse_nxt;
        decel_point_r <= decel_point_nxt;
        period_r      <= period_nxt;
        decel_r       <= decel_nxt;
        elapsed_r     <= elapsed_nxt;
        latch_r       <= latch_nxt;
      end else if (cmd.commit) begin
        period_r <= period_ramp;
      end
    end
  end

  // Multiplier word and the result item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r     <= {{(PROD_W-ACCEL_W){1'b0}}, accel_r};
      carry_r <= '0;
      step_r  <= step;
      dir_r   <= reverse_nxt;
      pos_r   <= cur_nxt;
      done_r  <= (cur_nxt == target_nxt);
      fault_r <= fault;
    end else if (cmd.mul_en) begin
      w_r     <= {prod[LIMB_W-1:0], w_r[PROD_W-1:LIMB_W]};
      carry_r <= cmd.limb_last ? '0 : prod[2*LIMB_W-1:LIMB_W];
    end
  end

  assign out_step_pulse = step_r;
  assign out_direction  = dir_r;
  assign out_position   = pos_r;
  assign out_done_res   = done_r;
  assign out_stop_fault = fault_r;

endmodule
`default_nettype wire

>>> tb/sv/stepper_trapezoid_ramp_generator_top_test.sv
module stepper_trapezoid_ramp_generator_top_test;
  import strg_pkg::*;

  typedef struct packed {
    func_t                   func;
    logic signed [POS_W-1:0] value;
    logic                    sw;
  } motor_cmd_t;

  typedef struct packed {
    logic                    step;
    logic                    dir;
    logic signed [POS_W-1:0] pos;
    logic                    done;
    logic                    fault;
  } motor_status_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  cfg_reg_t                cfg_index = REG_MIN_PERIOD;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  func_t                   in_func = FUNC_TICK;
  logic signed [POS_W-1:0] in_value = '0;
  logic                    in_switch_active = 1'b0;
  logic                    out_stall = 1'b0;
  wire                     in_stall;
  wire                     out_valid;
  wire                     out_step_pulse;
  wire                     out_direction;
  wire signed [POS_W-1:0]  out_position;
  wire                     out_done_res;
  wire                     out_stop_fault;

  stepper_trapezoid_ramp_generator_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_value         (in_value),
    .in_switch_active (in_switch_active),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_step_pulse   (out_step_pulse),
    .out_direction    (out_direction),
    .out_position     (out_position),
    .out_done_res     (out_done_res),
    .out_stop_fault   (out_stop_fault)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the registers and the motion state
  logic [PERIOD_W-1:0]     min_per = MIN_PERIOD_RST;
  logic [PERIOD_W-1:0]     first_per = FIRST_PERIOD_RST;
  logic [DECEL_W-1:0]      stop_steps = DECEL_STEPS_RST;
  logic [ACCEL_W-1:0]      accel = ACCEL_COEFF_RST;
  logic signed [POS_W-1:0] cur_pos = '0;
  logic signed [POS_W-1:0] tgt_pos = '0;
  logic                    rev = 1'b0;
  logic [DECEL_W-1:0]      brake_at = '0;
  logic [PERIOD_W-1:0]     period = '0;
  logic                    braking = 1'b0;
  logic [TICK_W-1:0]       waited = '0;
  logic                    latched = 1'b0;

  motor_cmd_t    pending_cmds[$];
  motor_status_t expected_status[$];
  motor_cmd_t    shown;
  logic          took = 1'b0;
  int            errors = 0;
  int            results_seen = 0;
  int            queued = 0;
  int            cyc = 0;
  int            hold_left = 0;
  int            holds_done = 0;
  int            hold_at = 60;

  // Steps left to the target, exact over the full signed range
  function automatic logic [POS_W:0] gap_to_target();
    logic signed [POS_W:0] d;
    d = {tgt_pos[POS_W-1], tgt_pos} - {cur_pos[POS_W-1], cur_pos};
    return d[POS_W] ? -d : d;
  endfunction

  // Next step period: p -/+ a*p^3, clamped at zero, all ones and the cruise period
  function automatic logic [PERIOD_W-1:0] ramp_period(logic [PERIOD_W-1:0] p);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] delta;
    logic [PROD_W-1:0] n;
    prod = PROD_W'(accel) * PROD_W'(p) * PROD_W'(p) * PROD_W'(p);
    delta = prod >> ACCEL_SHIFT;
    if (braking) begin
      n = PROD_W'(p) + delta;
      if (n[PROD_W-1:PERIOD_W] != '0) n = PROD_W'({PERIOD_W{1'b1}});
    end else begin
      n = (delta >= PROD_W'(p)) ? '0 : PROD_W'(p) - delta;
    end
    if (n < PROD_W'(min_per)) n = PROD_W'(min_per);
    return n[PERIOD_W-1:0];
  endfunction

  // Advance the motion state by one item and return its status
  function automatic motor_status_t motion_update(motor_cmd_t c);
    motor_status_t r;
    logic [POS_W:0] gap;
    r = '0;
    case (c.func)
      FUNC_START: begin
        tgt_pos = c.value;
        gap = gap_to_target();
        rev = tgt_pos < cur_pos;
        brake_at = stop_steps;
        if (gap <= {1'b0, stop_steps, 1'b0}) brake_at = gap[DECEL_W:1];
        period = first_per;
        braking = 1'b0;
        waited = '0;
      end
      FUNC_SETPOS: begin
        cur_pos = c.value;
        tgt_pos = c.value;
      end
      FUNC_LATCH: latched = c.value[0];
      FUNC_TICK: begin
        if (cur_pos != tgt_pos) begin
          if (c.sw && !latched) begin
            latched = 1'b1;
            tgt_pos = cur_pos;
            r.fault = 1'b1;
          end else begin
            if (waited != '1) waited++;
            if (waited >= TICK_W'(period >> FRAC_W)) begin
              if (gap_to_target() == {2'b00, brake_at}) braking = !braking;
              cur_pos = rev ? cur_pos - 1 : cur_pos + 1;
              period = ramp_period(period);
              waited = '0;
              r.step = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.dir = rev;
    r.pos = cur_pos;
    r.done = (cur_pos == tgt_pos);
    return r;
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic logic calm();
    return cyc >= 1500 && cyc < 3500;
  endfunction

  always @(posedge clk) cyc <= cyc + 1;

  // Predict on input accept, then compare the accepted result with the oldest prediction
  always @(posedge clk) begin : watch
    motor_status_t e;
    if (rst_n && in_valid && !in_stall) begin
      expected_status.push_back(motion_update(shown));
      took = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual position %0d", $time,
                 out_position);
        errors++;
      end else begin
        e = expected_status.pop_front();
        check_field("step_pulse", POS_W'(e.step), POS_W'(out_step_pulse));
        check_field("direction", POS_W'(e.dir), POS_W'(out_direction));
        check_field("position", e.pos, out_position);
        check_field("done_res", POS_W'(e.done), POS_W'(out_done_res));
        check_field("stop_fault", POS_W'(e.fault), POS_W'(out_stop_fault));
      end
      results_seen++;
    end
  end

  // Present the next pending item once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      took = 1'b0;
      if (pending_cmds.size() != 0 && (calm() || $urandom_range(0, 99) >= 11)) begin
        shown = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_func <= shown.func;
        in_value <= shown.value;
        in_switch_active <= shown.sw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall results at random, with two long hold-offs to back up the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && results_seen >= hold_at) begin
      hold_left = 80;
      holds_done++;
      hold_at += 250;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm() && $urandom_range(0, 99) < 11;
    end
  end

  task automatic push(func_t f, logic signed [POS_W-1:0] v, logic sw);
    pending_cmds.push_back('{func: f, value: v, sw: sw});
    queued++;
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_one(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
  endtask

  task automatic set_config(logic [31:0] mn, logic [31:0] fp, logic [31:0] ds,
                            logic [31:0] ac);
    write_one(REG_MIN_PERIOD, mn);
    write_one(REG_FIRST_PERIOD, fp);
    write_one(REG_DECEL_STEPS, ds);
    write_one(REG_ACCEL_COEFF, ac);
    @(negedge clk);
    cfg_we <= 1'b0;
    min_per = mn;
    first_per = fp;
    stop_steps = ds[DECEL_W-1:0];
    accel = ac;
  endtask

  // One short move with random content, or a burst of random items
  task automatic random_move();
    logic signed [POS_W-1:0] base;
    logic [POS_W-1:0]        v;
    int                      nt;
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 1) == 0) begin
        base = $urandom_range(0, 2000);
        base = base - 1000;
      end else begin
        base = $urandom;
      end
      push(FUNC_SETPOS, base, $urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0) begin
        v = $urandom;
        v[0] = ($urandom_range(0, 4) == 0);
        push(FUNC_LATCH, v, $urandom_range(0, 1));
      end
      push(FUNC_START, base + $urandom_range(0, 24) - 12, $urandom_range(0, 1));
      nt = $urandom_range(5, 50);
      repeat (nt) push(FUNC_TICK, $urandom, $urandom_range(0, 99) < 3);
    end else begin
      nt = $urandom_range(1, 6);
      repeat (nt) push(func_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1));
    end
  endtask

  initial begin : stimulus
    logic [31:0] mn;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, extremes of value, switch and latch cases
    push(FUNC_TICK, 32'sd0, 1'b0);
    push(FUNC_SETPOS, 32'sh7FFF_FFFF, 1'b0);
    push(FUNC_START, 32'sh8000_0000, 1'b1);
    push(FUNC_TICK, 32'sh0000_0000, 1'b0);
    push(FUNC_TICK, 32'shFFFF_FFFF, 1'b1);
    push(FUNC_TICK, 32'sd0, 1'b1);
    push(FUNC_LATCH, 32'shFFFF_FFFF, 1'b0);
    push(FUNC_SETPOS, 32'sh8000_0000, 1'b1);
    push(FUNC_START, 32'sh7FFF_FFFF, 1'b0);
    push(FUNC_TICK, 32'sd0, 1'b1);
    push(FUNC_LATCH, 32'shFFFF_FFFE, 1'b1);
    push(FUNC_START, 32'sd0, 1'b0);
    push(FUNC_TICK, 32'sd0, 1'b0);
    push(FUNC_SETPOS, -32'sd1, 1'b0);
    push(FUNC_START, -32'sd1, 1'b0);
    push(FUNC_TICK, 32'sd0, 1'b0);
    push(FUNC_START, 32'sd5, 1'b0);
    push(FUNC_TICK, 32'sd0, 1'b0);
    push(FUNC_SETPOS, 32'sd0, 1'b0);
    drain();

    // Cruise period at its maximum: one step, then stuck until cancelled
    set_config(32'hFFFF_FFFF, 32'h0001_0000, 32'd2, 32'd7);
    push(FUNC_SETPOS, 32'sd100, 1'b0);
    push(FUNC_START, 32'sd103, 1'b0);
    repeat (3) push(FUNC_TICK, 32'sd0, 1'b0);
    push(FUNC_SETPOS, 32'sd0, 1'b0);
    drain();

    // First period and deceleration distance at their maxima
    set_config(32'h0001_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push(FUNC_SETPOS, -32'sd5, 1'b0);
    push(FUNC_START, -32'sd9, 1'b0);
    repeat (4) push(FUNC_TICK, 32'sd0, 1'b0);
    push(FUNC_SETPOS, 32'sd0, 1'b0);
    drain();

    // Ramp at the largest acceleration coefficient: acceleration, then deceleration at the midpoint before cruise
    set_config(32'h0002_0000, 32'h0040_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push(FUNC_SETPOS, 32'sd10, 1'b0);
    push(FUNC_START, 32'sd16, 1'b0);
    repeat (300) push(FUNC_TICK, 32'sd0, 1'b0);
    drain();

    // Random moves over several settings, the first two fixed at extremes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(32'h0001_0000, 32'h0005_0000, 32'd3, 32'hFFFF_FFFF);
        1: set_config(32'h0002_0000, 32'h0028_007B, 32'd0, 32'd1);
        default: begin
          mn = 32'h0001_0000 + $urandom_range(0, 32'h1_FFFF);
          set_config(mn, mn + $urandom_range(0, 32'h5_FFFF), $urandom_range(0, 6),
                     ($urandom | 32'd1));
        end
      endcase
      queued = 0;
      while (queued < 12) random_move();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("stepper_trapezoid_ramp_generator_top_test passed");
    end else begin
      $display("stepper_trapezoid_ramp_generator_top_test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("stepper_trapezoid_ramp_generator_top_test failed");
    $finish;
  end

endmodule
